FILE: hw/rtl/odp_pkg.sv
// Shared types, constants and helper functions for the ordered dither palette mapper.
// No dependencies; every other file of the block uses this package by scoped names.
`default_nettype none

package odp_pkg;

  localparam int unsigned PIX_W         = 16;
  localparam int unsigned CH_W          = 5;
  localparam int unsigned SQ_W          = 10;
  localparam int unsigned ENTRY_W       = 15;
  localparam int unsigned GROUP_ENTRIES = 4;
  localparam int unsigned NUM_GROUPS    = 4;
  localparam int unsigned GROUP_W       = ENTRY_W * GROUP_ENTRIES;
  localparam int unsigned MAX_ENTRIES   = NUM_GROUPS * GROUP_ENTRIES;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned DIST_W        = 12;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = GROUP_W;

  typedef logic [DIST_W-1:0] dist_t;

  // Larger than any real distance (3 * 31 * 31 = 2883), so never strictly better.
  localparam dist_t DIST_NONE = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DITHER_ENABLE = 3'd0,
    REG_PALETTE_A     = 3'd1,
    REG_PALETTE_B     = 3'd2,
    REG_PALETTE_C     = 3'd3,
    REG_PALETTE_D     = 3'd4
  } cfg_reg_e;

  // Same bit order as a packed palette entry: red 14..10, green 9..5, blue 4..0.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Tournament node: best entry of a segment and the running best just before it.
  typedef struct packed {
    dist_t            best_dist;
    logic [IDX_W-1:0] idx;
    logic             has_prev;
    dist_t            prev_dist;
    logic [IDX_W-1:0] prev_idx;
  } node_t;

  // 4x4 Bayer offset, rank already folded in (rank 0 -> -3 ... rank 15 -> +3).
  function automatic logic signed [2:0] bayer_offset(input logic [1:0] row,
                                                     input logic [1:0] col);
    logic signed [2:0] off;
    case ({row, col})
      4'h0:    off = -3'sd3;  // rank 0
      4'h1:    off =  3'sd0;  // rank 8
      4'h2:    off = -3'sd2;  // rank 2
      4'h3:    off =  3'sd0;  // rank 10
      4'h4:    off =  3'sd1;  // rank 12
      4'h5:    off = -3'sd1;  // rank 4
      4'h6:    off =  3'sd2;  // rank 14
      4'h7:    off =  3'sd0;  // rank 6
      4'h8:    off = -3'sd2;  // rank 3
      4'h9:    off =  3'sd1;  // rank 11
      4'hA:    off = -3'sd3;  // rank 1
      4'hB:    off =  3'sd0;  // rank 9
      4'hC:    off =  3'sd3;  // rank 15
      4'hD:    off =  3'sd0;  // rank 7
      4'hE:    off =  3'sd2;  // rank 13
      4'hF:    off = -3'sd1;  // rank 5
      default: off =  3'sd0;
    endcase
    return off;
  endfunction

  function automatic logic [CH_W-1:0] dither_channel(input logic [CH_W-1:0] ch,
                                                     input logic signed [2:0] off);
    logic signed [CH_W+1:0] sum;
    logic [CH_W-1:0]        res;
    sum = $signed({2'b00, ch}) + $signed({{(CH_W-1){off[2]}}, off});
    if (sum[CH_W+1]) begin
      res = '0;
    end else if (sum[CH_W]) begin
      res = '1;
    end else begin
      res = sum[CH_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    logic [SQ_W-1:0] dw;
    d  = (a > b) ? (a - b) : (b - a);
    dw = {{(SQ_W-CH_W){1'b0}}, d};
    return dw * dw;
  endfunction

  // lo covers the lower indices; hi wins only when strictly smaller.
  function automatic node_t combine_nodes(input node_t lo, input node_t hi);
    node_t res;
    res = lo;
    if (hi.best_dist < lo.best_dist) begin
      res.best_dist = hi.best_dist;
      res.idx       = hi.idx;
      res.has_prev  = 1'b1;
      if (hi.has_prev && (hi.prev_dist < lo.best_dist)) begin
        res.prev_dist = hi.prev_dist;
        res.prev_idx  = hi.prev_idx;
      end else begin
        res.prev_dist = lo.best_dist;
        res.prev_idx  = lo.idx;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/odp_if.sv
// Valid/ready channel interfaces of the ordered dither palette mapper.
// Depends on odp_pkg for payload widths.
`default_nettype none

interface odp_in_if;
  logic                        valid;
  logic                        ready;
  logic [odp_pkg::PIX_W-1:0]   pixel;
  logic [1:0]                  column_phase;
  logic [1:0]                  row_phase;

  modport source (output valid, pixel, column_phase, row_phase, input ready);
  modport sink   (input valid, pixel, column_phase, row_phase, output ready);
endinterface

interface odp_out_if;
  logic                        valid;
  logic                        ready;
  logic [odp_pkg::IDX_W-1:0]   palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

interface odp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [odp_pkg::CFG_IDX_W-1:0]  index;
  logic [odp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/odp_dither.sv
// First pipeline stage: unpack the pixel, add the Bayer offset when dithering is enabled and clamp each channel.
// Depends on odp_pkg.
`default_nettype none

module odp_dither (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  output logic                       ready_o,
  input  wire [odp_pkg::PIX_W-1:0]   pixel_i,
  input  wire [1:0]                  column_phase_i,
  input  wire [1:0]                  row_phase_i,
  input  wire                        dither_enable_i,
  output logic                       valid_o,
  input  wire                        ready_i,
  output odp_pkg::rgb_t              color_o
);

  logic              valid_q;
  odp_pkg::rgb_t     color_d, color_q;
  logic signed [2:0] off;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    off = dither_enable_i ? odp_pkg::bayer_offset(row_phase_i, column_phase_i) : 3'sd0;
    color_d.red   = odp_pkg::dither_channel(pixel_i[15:11], off);
    color_d.green = odp_pkg::dither_channel(pixel_i[10:6], off);
    color_d.blue  = odp_pkg::dither_channel(pixel_i[4:0], off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      color_q <= color_d;
    end
  end

  assign valid_o = valid_q;
  assign color_o = color_q;

endmodule

`default_nettype wire

FILE: hw/rtl/odp_dist.sv
// Second pipeline stage: squared distance from the color to every palette entry.
// Depends on odp_pkg.
`default_nettype none

module odp_dist #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire                                                   clk_i,
  input  wire                                                   rst_ni,
  input  wire                                                   valid_i,
  output logic                                                  ready_o,
  input  odp_pkg::rgb_t                                         color_i,
  input  wire [odp_pkg::MAX_ENTRIES-1:0][odp_pkg::ENTRY_W-1:0]  entries_i,
  output logic                                                  valid_o,
  input  wire                                                   ready_i,
  output odp_pkg::dist_t [odp_pkg::MAX_ENTRIES-1:0]             dist_o
);

  logic                                          valid_q;
  odp_pkg::dist_t [odp_pkg::MAX_ENTRIES-1:0]     dist_d, dist_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int k = 0; k < odp_pkg::MAX_ENTRIES; k++) begin
      odp_pkg::rgb_t ent;
      ent = entries_i[k];
      if (k < PALETTE_ENTRIES) begin
        dist_d[k] = odp_pkg::dist_t'(odp_pkg::sq_diff(color_i.red, ent.red))
                  + odp_pkg::dist_t'(odp_pkg::sq_diff(color_i.green, ent.green))
                  + odp_pkg::dist_t'(odp_pkg::sq_diff(color_i.blue, ent.blue));
      end else begin
        dist_d[k] = odp_pkg::DIST_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dist_q <= dist_d;
    end
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

FILE: hw/rtl/odp_tree.sv
// Third and fourth pipeline stages: registered tournament tree over the distances,
// two levels per stage, giving the first minimum and the running best before it.
// Depends on odp_pkg.
`default_nettype none

module odp_tree (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        valid_i,
  output logic                                       ready_o,
  input  odp_pkg::dist_t [odp_pkg::MAX_ENTRIES-1:0]  dist_i,
  output logic                                       valid_o,
  input  wire                                        ready_i,
  output odp_pkg::node_t                             root_o
);

  localparam int unsigned L1_N  = odp_pkg::MAX_ENTRIES / 2;
  localparam int unsigned MID_N = odp_pkg::MAX_ENTRIES / 4;

  odp_pkg::node_t [odp_pkg::MAX_ENTRIES-1:0] leaf;
  odp_pkg::node_t [L1_N-1:0]                 lvl1;
  odp_pkg::node_t [MID_N-1:0]                mid_d, mid_q;
  odp_pkg::node_t [1:0]                      lvl3;
  odp_pkg::node_t                            root_d, root_q;
  logic                                      mid_valid_q, root_valid_q;
  logic                                      mid_ready;

  // Upper stage first: it sets whether the middle register may advance.
  assign mid_ready = !root_valid_q || ready_i;
  assign ready_o   = !mid_valid_q || mid_ready;

  always_comb begin
    for (int k = 0; k < odp_pkg::MAX_ENTRIES; k++) begin
      leaf[k].best_dist = dist_i[k];
      leaf[k].idx       = odp_pkg::IDX_W'(k);
      leaf[k].has_prev  = 1'b0;
      leaf[k].prev_dist = dist_i[k];
      leaf[k].prev_idx  = odp_pkg::IDX_W'(k);
    end
    for (int k = 0; k < L1_N; k++) begin
      lvl1[k] = odp_pkg::combine_nodes(leaf[2*k], leaf[2*k+1]);
    end
    for (int k = 0; k < MID_N; k++) begin
      mid_d[k] = odp_pkg::combine_nodes(lvl1[2*k], lvl1[2*k+1]);
    end
  end

  always_comb begin
    lvl3[0] = odp_pkg::combine_nodes(mid_q[0], mid_q[1]);
    lvl3[1] = odp_pkg::combine_nodes(mid_q[2], mid_q[3]);
    root_d  = odp_pkg::combine_nodes(lvl3[0], lvl3[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q  <= 1'b0;
      root_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mid_valid_q <= valid_i;
      end
      if (mid_ready) begin
        root_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      mid_q <= mid_d;
    end
    if (mid_ready && mid_valid_q) begin
      root_q <= root_d;
    end
  end

  assign valid_o = root_valid_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_dither_palette_map_core.sv
// Top level of the ordered dither palette mapper: configuration registers, the
// pipeline stages and the grey-avoidance output stage. Depends on odp_pkg, odp_if,
// odp_dither, odp_dist and odp_tree.
//
//   channel  | dir | payload                                 | accepted when
//   ---------+-----+-----------------------------------------+-------------------------
//   in_i     | in  | pixel[15:0], column_phase, row_phase    | in_i.valid & in_i.ready
//   out_o    | out | palette_index[3:0]                      | out_o.valid & out_o.ready
//   cfg_i    | in  | index[2:0], data[59:0]                  | cfg_i.valid (always ready)
//
// One item per cycle sustained while out_o is ready; each item passes five register
// stages (dither, distances, two tree stages, grey check) before its index is
// offered on out_o.
// Every stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stall at out_o holds all data.
// Reset clears the valid bits, dither_enable and the palette to zero.
// Configuration writes complete in the cycle they are presented.
`default_nettype none

module ordered_dither_palette_map_core #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  odp_in_if.sink      in_i,
  odp_out_if.source   out_o,
  odp_cfg_if.sink     cfg_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                                                   dither_enable_q;
  logic [odp_pkg::NUM_GROUPS-1:0][odp_pkg::GROUP_W-1:0]   palette_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_enable_q <= 1'b0;
      palette_q       <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        odp_pkg::REG_DITHER_ENABLE: dither_enable_q <= cfg_i.data[0];
        odp_pkg::REG_PALETTE_A:     palette_q[0]    <= cfg_i.data;
        odp_pkg::REG_PALETTE_B:     palette_q[1]    <= cfg_i.data;
        odp_pkg::REG_PALETTE_C:     palette_q[2]    <= cfg_i.data;
        odp_pkg::REG_PALETTE_D:     palette_q[3]    <= cfg_i.data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Unpack the groups into one entry per slot and flag the grey ones.
  logic [odp_pkg::MAX_ENTRIES-1:0][odp_pkg::ENTRY_W-1:0] entries;
  logic [odp_pkg::MAX_ENTRIES-1:0]                       is_grey;

  always_comb begin
    for (int k = 0; k < odp_pkg::MAX_ENTRIES; k++) begin
      odp_pkg::rgb_t ent;
      ent = palette_q[k / odp_pkg::GROUP_ENTRIES]
                     [(k % odp_pkg::GROUP_ENTRIES) * odp_pkg::ENTRY_W +: odp_pkg::ENTRY_W];
      entries[k] = ent;
      is_grey[k] = (ent.red == ent.green) && (ent.red == ent.blue);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: dither and clamp
  // ---------------------------------------------------------------------------
  logic          s1_valid, s1_ready;
  odp_pkg::rgb_t s1_color;

  odp_dither u_dither (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_i.valid),
    .ready_o        (in_i.ready),
    .pixel_i        (in_i.pixel),
    .column_phase_i (in_i.column_phase),
    .row_phase_i    (in_i.row_phase),
    .dither_enable_i(dither_enable_q),
    .valid_o        (s1_valid),
    .ready_i        (s1_ready),
    .color_o        (s1_color)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: squared distance to each palette entry
  // ---------------------------------------------------------------------------
  logic                                       s2_valid, s2_ready;
  odp_pkg::dist_t [odp_pkg::MAX_ENTRIES-1:0]  s2_dist;

  odp_dist #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (s1_ready),
    .color_i  (s1_color),
    .entries_i(entries),
    .valid_o  (s2_valid),
    .ready_i  (s2_ready),
    .dist_o   (s2_dist)
  );

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: tournament tree
  // ---------------------------------------------------------------------------
  logic           tree_valid, tree_ready;
  odp_pkg::node_t tree_root;

  odp_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s2_valid),
    .ready_o(s2_ready),
    .dist_i (s2_dist),
    .valid_o(tree_valid),
    .ready_i(tree_ready),
    .root_o (tree_root)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: grey avoidance and output register
  // ---------------------------------------------------------------------------
  // The previous best is entry 0 when entry 0 itself is the winner. Fall back to
  // it when the match is not exact and the winner is grey but the previous best
  // is not.
  logic                        out_valid_q;
  logic [odp_pkg::IDX_W-1:0]   out_index_d, out_index_q;
  logic [odp_pkg::IDX_W-1:0]   prev_idx;

  assign tree_ready = !out_valid_q || out_o.ready;

  always_comb begin
    prev_idx    = tree_root.has_prev ? tree_root.prev_idx : '0;
    out_index_d = tree_root.idx;
    if ((tree_root.best_dist != '0) && (tree_root.idx != prev_idx)
        && is_grey[tree_root.idx] && !is_grey[prev_idx]) begin
      out_index_d = prev_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tree_ready) begin
      out_valid_q <= tree_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_ready && tree_valid) begin
      out_index_q <= out_index_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.palette_index = out_index_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The chosen entry always lies within the configured palette.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.palette_index) < PALETTE_ENTRIES))
    else $error("palette_index beyond PALETTE_ENTRIES");

  // The running best before the winner always has a lower index.
  a_prev_below_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tree_valid && tree_root.has_prev) |-> (tree_root.prev_idx < tree_root.idx))
    else $error("previous best not below winner");

  // An exact match is never replaced by the grey fallback.
  a_exact_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tree_valid && tree_ready && (tree_root.best_dist == '0))
      |=> (out_o.palette_index == $past(tree_root.idx)))
    else $error("exact match replaced");

endmodule

`default_nettype wire
